FILE: rtl/tel_pkg.sv
// tel_pkg: shared types and constants for the tab expanding line window
// holds the result record, the queue push record and the register indexes
// no dependencies
package tel_pkg;

  localparam int TAB_STOP       = 4;
  localparam int MAX_LINE_BYTES = 4095;

  localparam int BYTE_W   = 8;
  localparam int LEFT_W   = 12;
  localparam int SCROLL_W = 16;
  localparam int VIEW_W   = 9;
  localparam int REP_W    = 9;
  localparam int COL_W    = 17;
  localparam int PHASE_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int STEP_W   = $clog2(TAB_STOP + 1);
  localparam int IDX_W    = 1;
  localparam int CFG_W    = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [IDX_W-1:0] REG_SCROLL_OFFSET = 1'b0;
  localparam logic [IDX_W-1:0] REG_VIEW_WIDTH    = 1'b1;

  localparam logic [VIEW_W-1:0] VIEW_WIDTH_RESET = 9'd80;

  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL      = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;

  typedef struct packed {
    logic              done;
    logic [REP_W-1:0]  rep;
    logic [BYTE_W-1:0] ch;
  } tel_res_t;

  typedef struct packed {
    logic [1:0] n;
    tel_res_t   r0;
    tel_res_t   r1;
  } tel_push_t;

endpackage

FILE: rtl/tel_render.sv
// tel_render: input register, line state and per-byte rendering logic
// emits up to two result records per byte into the output queue
// depends on tel_pkg
module tel_render (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tel_pkg::BYTE_W-1:0]    in_ch,
  input  logic [tel_pkg::LEFT_W-1:0]    in_left,
  input  logic                          cfg_we,
  input  logic [tel_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tel_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          room2,
  output tel_pkg::tel_push_t            push
);
  import tel_pkg::*;

  logic                  ir_valid_r, ir_valid_nxt;
  logic [BYTE_W-1:0]     ir_ch_r;
  logic [LEFT_W-1:0]     ir_left_r;
  logic                  fire;

  logic [SCROLL_W-1:0]   scroll_r;
  logic [VIEW_W-1:0]     view_r;

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [VIEW_W-1:0]     shown_r, shown_nxt;
  logic [1:0]            trail_r, trail_nxt;
  logic                  tvis_r, tvis_nxt;

  logic [LEFT_W-1:0]     left;
  logic [1:0]            seq_m1;
  logic                  is_tab, is_ctrl, full, vis, line_end;
  logic [STEP_W-1:0]     step;
  logic [COL_W:0]        next_col, start_col, span;
  logic [VIEW_W-1:0]     room, cnt, pad;
  logic                  e_valid;
  tel_res_t              e_res, m_res;

  assign fire     = ir_valid_r && room2;
  assign in_ready = !ir_valid_r || fire;

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (in_valid && in_ready) begin
      ir_valid_nxt = 1'b1;
    end else if (fire) begin
      ir_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else begin
      ir_valid_r <= ir_valid_nxt;
    end
    if (in_valid && in_ready) begin
      ir_ch_r   <= in_ch;
      ir_left_r <= in_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= '0;
      view_r   <= VIEW_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCROLL_OFFSET: scroll_r <= cfg_data[SCROLL_W-1:0];
        REG_VIEW_WIDTH:    view_r   <= cfg_data[VIEW_W-1:0];
        default:           ;
      endcase
    end
  end

  // utf-8 sequence length minus one, zero when fewer bytes are left than the sequence needs
  always_comb begin
    seq_m1 = 2'd0;
    if (ir_ch_r[7:5] == 3'b110 && left >= LEFT_W'(2)) begin
      seq_m1 = 2'd1;
    end else if (ir_ch_r[7:4] == 4'b1110 && left >= LEFT_W'(3)) begin
      seq_m1 = 2'd2;
    end else if (ir_ch_r[7:3] == 5'b11110 && left >= LEFT_W'(4)) begin
      seq_m1 = 2'd3;
    end
  end

  assign left     = (ir_left_r > LEFT_W'(MAX_LINE_BYTES)) ? LEFT_W'(MAX_LINE_BYTES) : ir_left_r;
  assign line_end = (left <= LEFT_W'(1));
  assign is_tab   = (ir_ch_r == CH_TAB);
  assign is_ctrl  = (ir_ch_r < CH_SPACE) || (ir_ch_r == CH_DEL);
  assign full     = (shown_r >= view_r);
  assign step     = is_tab ? STEP_W'(TAB_STOP) - STEP_W'(phase_r) : STEP_W'(1);
  assign next_col = {1'b0, col_r} + (COL_W+1)'(step);
  assign vis      = (next_col > (COL_W+1)'(scroll_r));
  assign start_col = ({1'b0, col_r} > (COL_W+1)'(scroll_r)) ? {1'b0, col_r}
                                                          : (COL_W+1)'(scroll_r);
  assign span     = next_col - start_col;
  assign room     = view_r - shown_r;
  assign cnt      = (VIEW_W'(span[STEP_W-1:0]) > room) ? room : VIEW_W'(span[STEP_W-1:0]);

  always_comb begin
    col_nxt   = col_r;
    phase_nxt = phase_r;
    shown_nxt = shown_r;
    trail_nxt = trail_r;
    tvis_nxt  = tvis_r;
    e_valid   = 1'b0;
    e_res     = '{done: 1'b0, rep: REP_W'(1), ch: ir_ch_r};
    m_res     = '{done: 1'b1, rep: '0, ch: CH_SPACE};
    pad       = '0;
    push      = '0;

    if (left != '0) begin
      if (trail_r != 2'd0) begin
        trail_nxt = trail_r - 2'd1;
        e_valid   = tvis_r;
      end else begin
        trail_nxt = seq_m1;
        tvis_nxt  = 1'b0;
        if (!full) begin
          col_nxt = next_col[COL_W-1:0];
          if (is_tab || phase_r == PHASE_W'(TAB_STOP - 1)) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_r + PHASE_W'(1);
          end
          if (vis) begin
            if (is_tab) begin
              e_valid   = 1'b1;
              e_res.ch  = CH_SPACE;
              e_res.rep = cnt;
              shown_nxt = shown_r + cnt;
            end else if (is_ctrl) begin
              e_valid   = 1'b1;
              e_res.ch  = CH_QUESTION;
              shown_nxt = shown_r + VIEW_W'(1);
            end else if (col_r >= COL_W'(scroll_r)) begin
              e_valid   = 1'b1;
              shown_nxt = shown_r + VIEW_W'(1);
              tvis_nxt  = 1'b1;
            end
          end
        end
      end
    end

    push.r0 = e_res;
    push.n  = {1'b0, e_valid};

    if (line_end) begin
      pad = (view_r > shown_nxt) ? view_r - shown_nxt : '0;
      m_res.rep = pad;
      if (pad == '0 && e_valid) begin
        push.r0.done = 1'b1;
      end else if (e_valid) begin
        push.r1 = m_res;
        push.n  = 2'd2;
      end else begin
        push.r0 = m_res;
        push.n  = 2'd1;
      end
      col_nxt   = '0;
      phase_nxt = '0;
      shown_nxt = '0;
      trail_nxt = 2'd0;
      tvis_nxt  = 1'b0;
    end

    if (!fire) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      phase_r <= '0;
      shown_r <= '0;
      trail_r <= 2'd0;
      tvis_r  <= 1'b0;
    end else if (fire) begin
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      shown_r <= shown_nxt;
      trail_r <= trail_nxt;
      tvis_r  <= tvis_nxt;
    end
  end

  // a line end always leaves a result carrying the end flag
  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && line_end) |-> (push.n != 2'd0))
    else $error("line end without result");

  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !line_end) |-> (!push.r0.done && push.n != 2'd2))
    else $error("end flag or second result mid line");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && line_end) |=> (col_r == '0 && shown_r == '0 && trail_r == 2'd0))
    else $error("line state not cleared at line end");

endmodule

FILE: rtl/tel_out_queue.sv
// tel_out_queue: four-entry result queue between the renderer and the result channel
// takes up to two records per cycle, hands out one per transaction
// depends on tel_pkg
module tel_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tel_pkg::tel_push_t push,
  output logic               room2,
  output logic               head_valid,
  input  logic               head_ready,
  output tel_pkg::tel_res_t  head
);
  import tel_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  tel_res_t            slot_r [DEPTH];
  logic [PTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PTR_W:0]      cnt_r, cnt_nxt;
  logic                pop;

  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rp_r];
  assign pop        = head_valid && head_ready;
  assign room2      = (cnt_r <= (PTR_W+1)'(DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push.n);
    rp_nxt  = rp_r + PTR_W'(pop);
    cnt_nxt = cnt_r + (PTR_W+1)'(push.n) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slot_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slot_r[wp_r + PTR_W'(1)] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room2)
    else $error("push without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(DEPTH))
    else $error("queue count out of range");

  // a waiting head stays put until it is taken
  a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !head_ready) |=> (head_valid && $stable(head)))
    else $error("head changed while waiting");

endmodule

FILE: rtl/tab_expanding_line_window.sv
// tab_expanding_line_window: renders a horizontal window of a text line, one byte per transaction
// a byte passes the input register, then the result queue, before its result is offered
// one byte per cycle while not stalled; a glyph plus padding at a line end makes two results
// the input stalls while more than two results wait in the four-entry result queue
// reset: line state and queue cleared, scroll offset 0, view width 80
// depends on tel_pkg, tel_render, tel_out_queue
module tab_expanding_line_window (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tel_pkg::IN_TDATA_W-1:0]     in_tdata,   // in_byte, bytes_left
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tel_pkg::OUT_TDATA_W-1:0]    out_tdata,  // out_byte, repeat_res
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [tel_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tel_pkg::CFG_W-1:0]          cfg_data
);
  import tel_pkg::*;

  tel_push_t push;
  tel_res_t  head;
  logic      room2;

  tel_render u_render (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tdata[BYTE_W-1:0]),
    .in_left   (in_tdata[BYTE_W+LEFT_W-1:BYTE_W]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room2     (room2),
    .push      (push)
  );

  tel_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {(OUT_TDATA_W-BYTE_W-REP_W)'(0), head.rep, head.ch};
  assign out_tlast = head.done;

endmodule

FILE: test/tb.sv
// tb: self-checking bench for tab_expanding_line_window, line bytes in, screen runs out
// predicts every run in its own model and checks it field by field
// depends on tel_pkg and the tab_expanding_line_window rtl
`timescale 1ns / 1ps

module tb;
  import tel_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] ch;
    logic [LEFT_W-1:0] left;
  } line_byte_t;

  localparam int unsigned COL_MASK   = 32'h1FFFF;
  localparam int          IDLE_LIMIT = 3000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // in_byte, bytes_left
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_byte, repeat_res
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  line_byte_t  pending_bytes[$];
  tel_res_t    screen_runs[$];

  // predictor state
  int unsigned scroll_col = 0;
  int unsigned view_w = VIEW_WIDTH_RESET;
  int unsigned disp_col = 0;
  int unsigned shown = 0;
  int unsigned trail_cnt = 0;
  bit          trail_show = 0;

  bit          steady = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_cnt = 0;
  bit          hold_used = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  int          bytes_in = 0;
  int          runs_out = 0;
  int          queued = 0;

  tab_expanding_line_window uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void render_byte(input logic [BYTE_W-1:0] b,
                                      input logic [LEFT_W-1:0] left_in);
    tel_res_t    runs[2];
    int          n;
    int unsigned left, len, col, w, nxt, start, cnt, room, pad;
    n = 0;
    left = left_in;
    if (left > MAX_LINE_BYTES) left = MAX_LINE_BYTES;
    if (left != 0) begin
      if (trail_cnt != 0) begin
        trail_cnt--;
        if (trail_show) begin
          runs[n] = '{done: 1'b0, rep: 9'd1, ch: b};
          n++;
        end
      end else begin
        if (b < 8'h80) len = 1;
        else if ((b & 8'hE0) == 8'hC0 && left >= 2) len = 2;
        else if ((b & 8'hF0) == 8'hE0 && left >= 3) len = 3;
        else if ((b & 8'hF8) == 8'hF0 && left >= 4) len = 4;
        else len = 1;
        trail_cnt = (len - 1) & 3;
        trail_show = 0;
        if (shown < view_w) begin
          col = disp_col;
          w = (b == CH_TAB) ? TAB_STOP - (col % TAB_STOP) : 1;
          nxt = col + w;
          disp_col = nxt & COL_MASK;
          if (nxt > scroll_col) begin
            if (b == CH_TAB) begin
              start = (col > scroll_col) ? col : scroll_col;
              cnt = nxt - start;
              room = view_w - shown;
              if (cnt > room) cnt = room;
              runs[n] = '{done: 1'b0, rep: REP_W'(cnt), ch: CH_SPACE};
              n++;
              shown += cnt;
            end else if (b < 8'h20 || b == CH_DEL) begin
              runs[n] = '{done: 1'b0, rep: 9'd1, ch: CH_QUESTION};
              n++;
              shown += 1;
            end else if (col >= scroll_col) begin
              runs[n] = '{done: 1'b0, rep: 9'd1, ch: b};
              n++;
              shown += 1;
              trail_show = 1;
            end
          end
        end
      end
    end
    if (left <= 1) begin
      pad = (view_w > shown) ? view_w - shown : 0;
      if (pad == 0 && n > 0) begin
        runs[n-1].done = 1'b1;
      end else begin
        runs[n] = '{done: 1'b1, rep: REP_W'(pad), ch: CH_SPACE};
        n++;
      end
      disp_col = 0;
      shown = 0;
      trail_cnt = 0;
      trail_show = 0;
    end
    for (int i = 0; i < n; i++) screen_runs = {screen_runs, runs[i]};
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        render_byte(in_tdata[7:0], in_tdata[19:8]);
        bytes_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          line_byte_t nb;
          nb = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, nb.left, nb.ch};
          send_gap = steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (screen_runs.size() == 0) begin
          $error("unexpected run: out_byte %0h repeat_res %0d line_done %0b",
                 out_tdata[7:0], out_tdata[16:8], out_tlast);
          errors++;
        end else begin
          tel_res_t want;
          want = screen_runs.pop_front();
          if (out_tdata[7:0] !== want.ch) begin
            $error("out_byte: expected %0h, got %0h", want.ch, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[16:8] !== want.rep) begin
            $error("repeat_res: expected %0d, got %0d", want.rep, out_tdata[16:8]);
            errors++;
          end
          if (out_tlast !== want.done) begin
            $error("line_done: expected %0b, got %0b", want.done, out_tlast);
            errors++;
          end
        end
        runs_out++;
        recv_gap = steady ? 0 : $urandom_range(0, 3);
      end
      // one long hold-off while the sender keeps offering bytes
      if (!hold_used && pending_bytes.size() > 40) begin
        hold_used = 1;
        hold_cnt = 150;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_byte(input logic [BYTE_W-1:0] ch, input int unsigned left);
    line_byte_t nb;
    nb.ch = ch;
    nb.left = LEFT_W'(left);
    pending_bytes = {pending_bytes, nb};
    queued++;
  endfunction

  // cut: 0 whole line, 1 ends early with bytes_left 1, 2 ends early with an empty-line byte
  function automatic void queue_text(input logic [BYTE_W-1:0] txt[$], input int cut);
    int unsigned len, stop;
    len = txt.size();
    if (len == 0) begin
      push_byte(8'($urandom_range(0, 255)), 0);
      return;
    end
    stop = (cut == 0) ? len : $urandom_range(0, len - 1);
    for (int unsigned k = 0; k < stop; k++) push_byte(txt[k], len - k);
    if (cut == 1) push_byte(txt[stop], 1);
    else if (cut == 2) push_byte(8'($urandom_range(0, 255)), 0);
  endfunction

  function automatic void add_line(input int unsigned len, input int cut);
    logic [BYTE_W-1:0] txt[$];
    int                k;
    while (txt.size() < len) begin
      case ($urandom_range(0, 9))
        4: txt = {txt, CH_TAB};
        5: txt = {txt, ($urandom_range(0, 1) ? CH_DEL : 8'($urandom_range(0, 8'h1F)))};
        6, 7: begin
          k = $urandom_range(1, 3);
          if (k == 1) txt = {txt, 8'hC0 | 8'($urandom_range(0, 31))};
          else if (k == 2) txt = {txt, 8'hE0 | 8'($urandom_range(0, 15))};
          else txt = {txt, 8'hF0 | 8'($urandom_range(0, 7))};
          repeat (k) txt = {txt, 8'h80 | 8'($urandom_range(0, 63))};
        end
        8: txt = {txt, 8'($urandom_range(0, 255))};
        9: txt = {txt, 8'($urandom_range(8'h80, 8'hBF))};
        default: txt = {txt, 8'($urandom_range(8'h20, 8'h7E))};
      endcase
    end
    // a multibyte character may overrun the line and gets cut short
    while (txt.size() > len) void'(txt.pop_back());
    queue_text(txt, cut);
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCROLL_OFFSET: scroll_col = val & 32'hFFFF;
      REG_VIEW_WIDTH:    view_w = val & 32'h1FF;
      default: ;
    endcase
  endtask

  // block is idle once every byte is in and every run is out, plus pipeline slack
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || screen_runs.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  int unsigned scroll_set[8] = '{0, 0, 65535, 2, 0, 7, 0, 1};
  int unsigned width_set[8]  = '{80, 0, 511, 8, 256, 20, 0, 511};

  initial begin
    int target;
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tab under scroll, control bytes, utf-8, truncated lead, bare end marker
    write_reg(REG_SCROLL_OFFSET, 2);
    write_reg(REG_VIEW_WIDTH, 6);
    @(negedge clk);
    queue_text('{8'h09, 8'h41, 8'h01, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'hFF}, 0);
    wait_idle();

    // full window still passes continuation bytes of a shown character
    write_reg(REG_SCROLL_OFFSET, 0);
    write_reg(REG_VIEW_WIDTH, 3);
    @(negedge clk);
    queue_text('{8'h61, 8'h62, 8'hE2, 8'h82, 8'hAC, 8'hC3, 8'hA9}, 0);
    // line end while continuation bytes are owed
    push_byte(8'h78, 4);
    push_byte(8'hE2, 3);
    push_byte(8'h82, 1);
    push_byte(8'hA5, 0);
    queue_text('{8'h61, 8'h62, 8'h63}, 0);
    push_byte(8'h61, 4);
    push_byte(8'h62, 3);
    wait_idle();
    // narrower window in the middle of a line
    write_reg(REG_VIEW_WIDTH, 1);
    @(negedge clk);
    push_byte(8'h63, 2);
    push_byte(8'h64, 1);
    wait_idle();

    // random phases across window settings
    for (int p = 0; p < 8; p++) begin
      if (p == 6) begin
        scroll_set[p] = $urandom_range(0, 12);
        width_set[p] = $urandom_range(1, 40);
      end
      write_reg(REG_SCROLL_OFFSET, scroll_set[p]);
      write_reg(REG_VIEW_WIDTH, width_set[p]);
      @(negedge clk);
      steady = (p == 3);
      target = queued + 50;
      while (queued < target) begin
        r = $urandom_range(0, 19);
        if (r == 0) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4095));
        else if (r == 1) add_line(0, 0);
        else if (r <= 3) add_line($urandom_range(1, 30), $urandom_range(1, 2));
        else if (r == 4) add_line($urandom_range(60, 200), 0);
        else add_line($urandom_range(1, 30), 0);
      end
      wait_idle();
    end

    $display("covered %0d bytes in and %0d screen runs out", bytes_in, runs_out);
    $display("directed cases plus 8 window settings, widths 0 to 511, scroll up to 65535");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
